// File: hdl/fbadc_pkg.sv
// Package for the band-pass FIR core: widths, tap count, coefficient table,
// controller states, control structs and the output round/clamp function.
// No dependencies.
package fbadc_pkg;

  localparam int NUM_TAPS   = 31;
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
  localparam int SAMPLE_W   = 12;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 15;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int Y_W        = ACC_W - COEF_FRAC;
  localparam int OUT_MAX    = 4095;
  localparam int MID_SCALE  = 2048;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [TAP_IDX_W-1:0]       tap_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_FIN
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic rot;
  } tap_ctl_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctl_t;

  // Q1.15 band-pass coefficients, symmetric about tap 15.
  function automatic coef_t coef_at(tap_idx_t k);
    coef_t c;
    case (k)
      5'd0,  5'd30: c = -16'sd468;
      5'd1,  5'd29: c = -16'sd593;
      5'd2,  5'd28: c = -16'sd189;
      5'd3,  5'd27: c =  16'sd603;
      5'd4,  5'd26: c =  16'sd989;
      5'd5,  5'd25: c =  16'sd550;
      5'd6,  5'd24: c = -16'sd16;
      5'd7,  5'd23: c =  16'sd329;
      5'd8,  5'd22: c =  16'sd1313;
      5'd9,  5'd21: c =  16'sd1135;
      5'd10, 5'd20: c = -16'sd1410;
      5'd11, 5'd19: c = -16'sd4711;
      5'd12, 5'd18: c = -16'sd5191;
      5'd13, 5'd17: c = -16'sd1088;
      5'd14, 5'd16: c =  16'sd4941;
      5'd15:        c =  16'sd7807;
      default:      c =  16'sd0;
    endcase
    return c;
  endfunction

  // Round half up, restore mid-scale, clamp to 0..4095.
  function automatic logic [SAMPLE_W-1:0] out_sat(acc_t acc);
    acc_t                   rnd;
    logic signed [Y_W-1:0]  y;
    logic signed [Y_W:0]    ys;
    logic [SAMPLE_W-1:0]    res;
    rnd = acc + ACC_W'(2 ** (COEF_FRAC - 1));
    y   = $signed(rnd[ACC_W-1:COEF_FRAC]);
    ys  = $signed({y[Y_W-1], y}) + (Y_W + 1)'(MID_SCALE);
    if (ys < 0) begin
      res = '0;
    end else if (ys > (Y_W + 1)'(OUT_MAX)) begin
      res = SAMPLE_W'(OUT_MAX);
    end else begin
      res = ys[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/fbadc_taps.sv
// Circulating sample delay line: one word shifts out per cycle to the MAC while load or rotate is set.
// Depends on fbadc_pkg.
module fbadc_taps import fbadc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tap_ctl_t ctl,
  input  sample_t  din,
  output sample_t  tap_out
);

  sample_t taps_r   [NUM_TAPS];
  sample_t taps_nxt [NUM_TAPS];

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      taps_nxt[k] = taps_r[k];
    end
    if (ctl.load || ctl.rot) begin
      for (int k = 1; k < NUM_TAPS; k++) begin
        taps_nxt[k] = taps_r[k-1];
      end
      // load drops the oldest sample, rotate wraps it back to the front
      taps_nxt[0] = ctl.load ? din : taps_r[NUM_TAPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        taps_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        taps_r[k] <= taps_nxt[k];
      end
    end
  end

  assign tap_out = taps_r[NUM_TAPS-1];

endmodule

// File: hdl/fbadc_mac.sv
// Shared multiply-accumulate: registered product, then accumulate.
// Depends on fbadc_pkg.
module fbadc_mac import fbadc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  sample_t  sample,
  input  tap_idx_t coef_idx,
  output acc_t     acc
);

  prod_t prod_r;
  logic  prod_vld_r;
  acc_t  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * coef_at(coef_idx);
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

// File: hdl/fir_bandpass_adc_to_dac_core.sv
// 31-tap band-pass FIR, 12-bit unsigned in, 12-bit unsigned out.
// An input transfer starts the tap walk (S_MAC), then S_DRAIN and the round in S_FIN.
// Input is taken only in S_IDLE, so a new sample waits for the last one to finish, as
// the shared multiplier walks the delay line one tap per cycle; out_stall holds round.
// Reset (synchronous, rst_n low): delay line cleared to zero, controller idle,
// no output pending.
module fir_bandpass_adc_to_dac_core import fbadc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_dac_sample
);

  fsm_state_t          state_r, state_nxt;
  tap_idx_t            cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  tap_ctl_t            tap_ctl;
  mac_ctl_t            mac_ctl;
  sample_t             x_centred;
  sample_t             tap_out;
  acc_t                acc;

  // flip the MSB to subtract mid-scale
  assign x_centred = $signed({~in_adc_sample[SAMPLE_W-1], in_adc_sample[SAMPLE_W-2:0]});

  fbadc_taps u_taps (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tap_ctl),
    .din     (x_centred),
    .tap_out (tap_out)
  );

  fbadc_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .sample   (tap_out),
    .coef_idx (cnt_r),
    .acc      (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    tap_ctl       = '0;
    mac_ctl       = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          tap_ctl.load = 1'b1;
          mac_ctl.clr  = 1'b1;
          cnt_nxt      = TAP_IDX_W'(NUM_TAPS - 1);
          state_nxt    = S_MAC;
        end
      end
      S_MAC: begin
        tap_ctl.rot    = 1'b1;
        mac_ctl.mul_en = 1'b1;
        cnt_nxt        = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_sat(acc);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_dac_sample = out_data_r;

  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MAC && cnt_r == TAP_IDX_W'(NUM_TAPS - 1)))
    else $error("input transfer did not start the tap walk");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("output valid rose outside the round step");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (cnt_r <= TAP_IDX_W'(NUM_TAPS - 1)))
    else $error("tap counter out of range");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost or changed");

endmodule

// File: tb/fir_dac_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the band-pass FIR core: predicts each output sample from the
// accepted input samples and checks results in order. Depends on fbadc_pkg.
package fir_dac_tb_pkg;
  import fbadc_pkg::*;

  localparam int PROTO_TAPS = 31;
  localparam int PROTO_FRAC = 30;
  localparam int SHOWN_MISMATCHES = 10;

  class dac_scoreboard;
    coef_t               tap_coef [NUM_TAPS];
    sample_t             centred_history [NUM_TAPS-1];
    logic [SAMPLE_W-1:0] pending_dac [$];
    int unsigned         mismatches;

    // Q2.30 band-pass prototype, symmetric about the middle tap.
    static function longint proto_q30(int k);
      int     m;
      longint p;
      m = (k > PROTO_TAPS / 2) ? PROTO_TAPS - 1 - k : k;
      case (m)
        0:  p = -15322007;
        1:  p = -19439491;
        2:  p = -6191275;
        3:  p = 19756171;
        4:  p = 32397287;
        5:  p = 18017466;
        6:  p = -510667;
        7:  p = 10770749;
        8:  p = 43025741;
        9:  p = 37191449;
        10: p = -46214684;
        11: p = -154358417;
        12: p = -170094207;
        13: p = -35636917;
        14: p = 161910527;
        default: p = 255805981;
      endcase
      if (k >= PROTO_TAPS) begin
        p = 0;
      end
      return p;
    endfunction

    function void clear_history();
      int shift;
      shift = PROTO_FRAC - COEF_FRAC;
      // Round half up from the prototype down to the coefficient format.
      foreach (tap_coef[k]) begin
        tap_coef[k] = coef_t'((proto_q30(k) + (longint'(1) << (shift - 1))) >>> shift);
      end
      foreach (centred_history[k]) begin
        centred_history[k] = '0;
      end
      pending_dac.delete();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_dac.size();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] adc);
      sample_t x;
      longint  acc;
      longint  y;
      int      k;
      x   = sample_t'(int'(adc) - MID_SCALE);
      acc = longint'(tap_coef[0]) * longint'(x);
      for (k = 1; k < NUM_TAPS; k++) begin
        acc += longint'(tap_coef[k]) * longint'(centred_history[k-1]);
      end
      y = ((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC) + MID_SCALE;
      if (y < 0) begin
        y = 0;
      end else if (y > OUT_MAX) begin
        y = OUT_MAX;
      end
      pending_dac.push_back(y[SAMPLE_W-1:0]);
      // Advance the delay line, newest sample at the front.
      for (k = NUM_TAPS - 2; k > 0; k--) begin
        centred_history[k] = centred_history[k-1];
      end
      centred_history[0] = x;
    endfunction

    function void check_dac(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (pending_dac.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          $display("%0t: dac_sample transfer with nothing pending, actual %0d", $time, got);
        end
        return;
      end
      want = pending_dac.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          $display("%0t: dac_sample mismatch, expected %0d actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the band-pass FIR core testbench: clock, reset, sample source,
// result sink and timeout. Depends on fbadc_pkg and fir_dac_tb_pkg.
module tb_top;
  import fbadc_pkg::*;
  import fir_dac_tb_pkg::*;

  localparam int RANDOM_SAMPLES = 1000;
  localparam int CALM_TAIL      = 150;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RESET_CYCLES   = 7;
  localparam int MAX_IDLE       = 12;

  typedef enum int {
    PAT_UNIFORM,
    PAT_MATCHED,
    PAT_SQUARE,
    PAT_NEAR_MID,
    PAT_RAILS
  } pattern_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_adc_sample = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [SAMPLE_W-1:0] out_dac_sample;

  dac_scoreboard sb;
  bit            calm;
  int unsigned   sender_idle_rate;
  int unsigned   cycles;

  fir_bandpass_adc_to_dac_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL fir_bandpass_adc_to_dac_core");
      $finish;
    end
  end

  // Present one sample, hold it through stalls, and note it on transfer.
  task automatic send_sample(logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if (!calm && sender_idle_rate != 0 && $urandom_range(7, 0) < sender_idle_rate) begin
      gap = $urandom_range(MAX_IDLE, 1);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= value;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_sample(value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : sink
    int unsigned         burst_left;
    int unsigned         mode_left;
    bit                  stalls_on;
    bit                  fire;
    logic [SAMPLE_W-1:0] got;
    burst_left = 0;
    mode_left  = 0;
    stalls_on  = 1'b0;
    forever begin
      @(negedge clk);
      fire = rst_n && out_valid && !out_stall;
      got  = out_dac_sample;
      @(posedge clk);
      if (fire) begin
        sb.check_dac(got);
      end
      // Pick stretches at random with or without stall bursts.
      if (mode_left == 0) begin
        stalls_on = $urandom_range(2, 0) != 0;
        mode_left = $urandom_range(800, 200);
      end
      mode_left--;
      if (burst_left != 0) begin
        burst_left--;
      end else if (!calm && stalls_on && $urandom_range(5, 0) == 0) begin
        burst_left = $urandom_range(MAX_IDLE, 1);
      end
      out_stall <= (burst_left != 0);
    end
  end

  initial begin : stimulus
    int unsigned         sent;
    int unsigned         run_len;
    int unsigned         level_hi;
    int unsigned         level_lo;
    int unsigned         period;
    int unsigned         amp;
    int unsigned         j;
    bit                  flip;
    bit                  paused;
    pattern_t            mode;
    logic [SAMPLE_W-1:0] v;
    sb = new;
    sb.clear_history();
    sender_idle_rate = 2;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'hAAA);
    send_sample(12'h555);
    // Rails matched to the coefficient signs: drives the output into clamp.
    for (j = 0; j < 21; j++) begin
      send_sample((sb.tap_coef[20 - j] > 0) ? 12'd4095 : 12'd0);
    end
    wait_drained();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_SAMPLES) begin
      if (sent >= RANDOM_SAMPLES - CALM_TAIL) begin
        calm = 1'b1;
      end
      sender_idle_rate = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(3, 1);
      mode     = pattern_t'($urandom_range(PAT_RAILS, PAT_UNIFORM));
      run_len  = (mode == PAT_MATCHED) ? NUM_TAPS + $urandom_range(4, 0)
                                       : $urandom_range(40, 8);
      level_hi = $urandom_range(4095, 3500);
      level_lo = $urandom_range(600, 0);
      flip     = $urandom_range(1, 0) != 0;
      period   = $urandom_range(20, 2);
      amp      = $urandom_range(2047, 1);
      for (j = 0; j < run_len; j++) begin
        case (mode)
          PAT_UNIFORM: begin
            v = SAMPLE_W'($urandom_range(4095, 0));
          end
          PAT_MATCHED: begin
            // flip selects the high or the low clamp
            v = ((sb.tap_coef[j % NUM_TAPS] > 0) ^ flip) ? SAMPLE_W'(level_hi)
                                                         : SAMPLE_W'(level_lo);
          end
          PAT_SQUARE: begin
            v = ((j % period) < period / 2) ? SAMPLE_W'(MID_SCALE + amp)
                                            : SAMPLE_W'(MID_SCALE - amp);
          end
          PAT_NEAR_MID: begin
            v = SAMPLE_W'(MID_SCALE + $urandom_range(32, 0) - 16);
          end
          default: begin
            v = $urandom_range(1, 0) ? 12'd4095 : 12'd0;
          end
        endcase
        send_sample(v);
        sent++;
      end
      if (!paused && sent >= RANDOM_SAMPLES / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS fir_bandpass_adc_to_dac_core");
    end else begin
      $display("FAIL fir_bandpass_adc_to_dac_core");
    end
    $finish;
  end

endmodule
